// ===== design/assert_macros.svh =====
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, cond, expr)
`define ASSERT_NEXT(label, cond, expr)
`endif
`endif

// ===== design/lrbg_pkg.sv =====
package lrbg_pkg;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic               is_target;
  } in_t;

  typedef struct packed {
    logic signed [31:0] weight_value;
    logic [5:0]         weight_index;
    logic               last_weight;
  } out_t;

  localparam logic [1:0] CFG_FEATURE_COUNT = 2'd0;
  localparam logic [1:0] CFG_SAMPLE_COUNT  = 2'd1;
  localparam logic [1:0] CFG_EPOCH_COUNT   = 2'd2;
  localparam logic [1:0] CFG_LEARN_RATE    = 2'd3;

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    if (v[48] != v[47]) sat48 = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    else sat48 = v[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    if (v > 52'sd2147483647) sat32 = 32'h7FFFFFFF;
    else if (v < -52'sd2147483648) sat32 = 32'h80000000;
    else sat32 = v[31:0];
  endfunction

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) sadd64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else sadd64 = s[63:0];
  endfunction

endpackage

// ===== design/linear_regression_batch_gradient.sv =====
// Full-batch gradient descent trainer for multiple linear regression.
// Input channel: start/busy command handshake carrying in_data (sample value
// in Q4.11 and an is_target flag). A sample is its features, then its target.
// A feature is stored and its weight read when taken; busy then stays high
// while it is multiplied and accumulated. A feature beyond the configured
// count is dropped and leaves busy low. A target transfer computes the error,
// then each feature buffered for that sample is read, multiplied by the error
// and added into its gradient entry in memory. The target that ends an epoch
// adds the weight update for each weight and for the bias, using the 64-step
// shift-subtract divider. The target that ends the final epoch then emits
// the D weights (memory read, then strobe) and the bias flagged last_weight.
// Results appear on out_data for one cycle with out_valid; the receiver
// cannot stall them. After the bias the training state clears for a new run.
// Reset restores the default configuration and zeroes all training state
// at once via per-entry valid bits, no sweep needed. The user must write the
// configuration via cfg_we/cfg_index/cfg_data only while idle; not enforced.
`include "assert_macros.svh"

module linear_regression_batch_gradient #(
  parameter int MAX_FEATURES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lrbg_pkg::in_t      in_data,
  output logic               out_valid,
  output lrbg_pkg::out_t     out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [20:0]        cfg_data
);

  localparam int IW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam logic [5:0] MAXF = 6'(MAX_FEATURES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FMUL  = 4'd1;
  localparam logic [3:0] S_FACC  = 4'd2;
  localparam logic [3:0] S_TERR  = 4'd3;
  localparam logic [3:0] S_GRD   = 4'd4;
  localparam logic [3:0] S_GMUL  = 4'd5;
  localparam logic [3:0] S_GWR   = 4'd6;
  localparam logic [3:0] S_TEND  = 4'd7;
  localparam logic [3:0] S_URD   = 4'd8;
  localparam logic [3:0] S_ULD   = 4'd9;
  localparam logic [3:0] S_UDIV  = 4'd10;
  localparam logic [3:0] S_UMUL  = 4'd11;
  localparam logic [3:0] S_UWR   = 4'd12;
  localparam logic [3:0] S_ORD   = 4'd13;
  localparam logic [3:0] S_OOUT  = 4'd14;
  localparam logic [3:0] S_OBIAS = 4'd15;

  logic [3:0]  state_r;
  logic [5:0]  fc_r;
  logic [20:0] sc_r;
  logic [15:0] ec_r, lr_r;

  logic signed [31:0] wmem [MAX_FEATURES];
  logic signed [63:0] gmem [MAX_FEATURES];
  logic signed [15:0] fmem [MAX_FEATURES];
  logic signed [31:0] w_rd_r;
  logic signed [63:0] g_rd_r;
  logic signed [15:0] f_rd_r;
  logic [MAX_FEATURES-1:0] wval_r, gval_r;

  logic signed [47:0] acc_r;
  logic [5:0]         pos_r, have_r, j_r;
  logic [20:0]        samples_r;
  logic [15:0]        epochs_r;
  logic signed [31:0] bias_r, wop_r, err_r;
  logic signed [63:0] bgrad_r, gold_r;
  logic signed [15:0] val_r;
  logic signed [47:0] mul_r;
  logic [20:0]        rem_r;
  logic [63:0]        quo_r;
  logic [5:0]         cnt_r;
  logic               neg_r;
  logic signed [65:0] prod_r;
  logic               out_valid_r;
  lrbg_pkg::out_t     out_data_r;

  logic [5:0]  d;
  logic [20:0] n_eff;
  logic [15:0] e_eff;
  logic [IW-1:0] pidx, jidx, rd_addr;
  logic        accept, feat_ok;
  logic        w_we, g_we;
  logic signed [31:0] w_wd;
  logic signed [63:0] g_wd;
  logic [21:0] div_tmp;
  logic        div_bit;
  logic [47:0] qclamp;
  logic signed [48:0] gval;
  logic signed [65:0] delta;
  logic signed [31:0] new_w;
  logic signed [47:0] pred;
  logic signed [31:0] err_nxt;
  logic signed [63:0] op_sel;
  logic [21:0] s_inc;
  logic [16:0] e_inc;

  assign d       = (fc_r < MAXF) ? fc_r : MAXF;
  assign n_eff   = (sc_r == 21'd0) ? 21'd1 : sc_r;
  assign e_eff   = (ec_r == 16'd0) ? 16'd1 : ec_r;
  assign pidx    = pos_r[IW-1:0];
  assign jidx    = j_r[IW-1:0];
  assign rd_addr = (state_r == S_IDLE) ? pidx : jidx;
  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign feat_ok = accept && !in_data.is_target && (pos_r < d);

  assign div_tmp = {rem_r, quo_r[63]};
  assign div_bit = (div_tmp >= {1'b0, n_eff});
  assign qclamp  = (quo_r > 64'h0000_8000_0000_0000) ? 48'h8000_0000_0000 : quo_r[47:0];
  assign gval    = neg_r ? -$signed({1'b0, qclamp}) : $signed({1'b0, qclamp});
  assign delta   = prod_r >>> 15;
  assign new_w   = lrbg_pkg::sat32(52'(wop_r) - 52'(delta));
  assign pred    = lrbg_pkg::sat48(49'(acc_r) + 49'(bias_r >>> 12));
  assign err_nxt = lrbg_pkg::sat32(52'(pred) - 52'(val_r));
  assign op_sel  = (j_r == d) ? bgrad_r : (gval_r[jidx] ? g_rd_r : 64'sd0);
  assign s_inc   = 22'(samples_r) + 22'd1;
  assign e_inc   = 17'(epochs_r) + 17'd1;

  assign w_we = (state_r == S_UWR) && (j_r != d);
  assign w_wd = new_w;
  assign g_we = (state_r == S_GWR);
  assign g_wd = lrbg_pkg::sadd64(gold_r, 64'(mul_r));

  always_ff @(posedge clk) begin
    if (w_we) wmem[jidx] <= w_wd;
    w_rd_r <= wmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (g_we) gmem[jidx] <= g_wd;
    g_rd_r <= gmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (feat_ok) fmem[pidx] <= in_data.sample_value;
    f_rd_r <= fmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fc_r        <= 6'd20;
      sc_r        <= 21'd100000;
      ec_r        <= 16'd500;
      lr_r        <= 16'd3277;
      wval_r      <= '0;
      gval_r      <= '0;
      acc_r       <= '0;
      pos_r       <= '0;
      samples_r   <= '0;
      epochs_r    <= '0;
      bias_r      <= '0;
      bgrad_r     <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          lrbg_pkg::CFG_FEATURE_COUNT: fc_r <= cfg_data[5:0];
          lrbg_pkg::CFG_SAMPLE_COUNT:  sc_r <= cfg_data;
          lrbg_pkg::CFG_EPOCH_COUNT:   ec_r <= cfg_data[15:0];
          lrbg_pkg::CFG_LEARN_RATE:    lr_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            val_r <= in_data.sample_value;
            if (in_data.is_target) state_r <= S_TERR;
            else if (feat_ok) state_r <= S_FMUL;
          end
        end
        S_FMUL: begin
          mul_r   <= val_r * (wval_r[pidx] ? w_rd_r : 32'sd0);
          state_r <= S_FACC;
        end
        S_FACC: begin
          acc_r   <= lrbg_pkg::sat48(49'(acc_r) + 49'(mul_r >>> 23));
          pos_r   <= pos_r + 6'd1;
          state_r <= S_IDLE;
        end
        S_TERR: begin
          err_r   <= err_nxt;
          have_r  <= (pos_r < d) ? pos_r : d;
          j_r     <= '0;
          state_r <= (((pos_r < d) ? pos_r : d) == 6'd0) ? S_TEND : S_GRD;
        end
        S_GRD: state_r <= S_GMUL;
        S_GMUL: begin
          mul_r   <= err_r * f_rd_r;
          gold_r  <= gval_r[jidx] ? g_rd_r : 64'sd0;
          state_r <= S_GWR;
        end
        S_GWR: begin
          gval_r[jidx] <= 1'b1;
          j_r          <= j_r + 6'd1;
          state_r      <= (j_r + 6'd1 == have_r) ? S_TEND : S_GRD;
        end
        S_TEND: begin
          bgrad_r <= lrbg_pkg::sadd64(bgrad_r, 64'(err_r) <<< 11);
          acc_r   <= '0;
          pos_r   <= '0;
          j_r     <= '0;
          if (s_inc >= 22'(n_eff)) begin
            samples_r <= '0;
            state_r   <= S_URD;
          end else begin
            samples_r <= s_inc[20:0];
            state_r   <= S_IDLE;
          end
        end
        S_URD: state_r <= S_ULD;
        S_ULD: begin
          wop_r   <= (j_r == d) ? bias_r : (wval_r[jidx] ? w_rd_r : 32'sd0);
          neg_r   <= op_sel[63];
          quo_r   <= op_sel[63] ? 64'(-op_sel) : 64'(op_sel);
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_UDIV;
        end
        S_UDIV: begin
          rem_r <= div_bit ? 21'(div_tmp - {1'b0, n_eff}) : div_tmp[20:0];
          quo_r <= {quo_r[62:0], div_bit};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) state_r <= S_UMUL;
        end
        S_UMUL: begin
          prod_r  <= gval * $signed({1'b0, lr_r});
          state_r <= S_UWR;
        end
        S_UWR: begin
          if (j_r == d) begin
            bias_r  <= new_w;
            bgrad_r <= '0;
            j_r     <= '0;
            if (e_inc >= 17'(e_eff)) begin
              epochs_r <= '0;
              state_r  <= (d == 6'd0) ? S_OBIAS : S_ORD;
            end else begin
              epochs_r <= e_inc[15:0];
              state_r  <= S_IDLE;
            end
          end else begin
            wval_r[jidx] <= 1'b1;
            gval_r[jidx] <= 1'b0;
            j_r          <= j_r + 6'd1;
            state_r      <= S_URD;
          end
        end
        S_ORD: state_r <= S_OOUT;
        S_OOUT: begin
          out_valid_r             <= 1'b1;
          out_data_r.weight_value <= wval_r[jidx] ? w_rd_r : 32'sd0;
          out_data_r.weight_index <= j_r;
          out_data_r.last_weight  <= 1'b0;
          j_r                     <= j_r + 6'd1;
          state_r                 <= (j_r + 6'd1 == d) ? S_OBIAS : S_ORD;
        end
        S_OBIAS: begin
          // end of run: emit bias and drop all training state
          out_valid_r             <= 1'b1;
          out_data_r.weight_value <= bias_r;
          out_data_r.weight_index <= d;
          out_data_r.last_weight  <= 1'b1;
          wval_r                  <= '0;
          gval_r                  <= '0;
          bias_r                  <= '0;
          bgrad_r                 <= '0;
          j_r                     <= '0;
          state_r                 <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEXT(a_last_ends_run, out_valid && out_data.last_weight, !out_valid && !busy)
  `ASSERT_NEXT(a_feature_mac, feat_ok, state_r == S_FMUL)
  `ASSERT_IMPL(a_index_range, out_valid, out_data.weight_index <= d)
  `ASSERT_IMPL(a_div_idle, state_r == S_IDLE, !out_valid || out_data.last_weight)

endmodule
